### sv/tcp_redirect_nat_table_unit_assert.svh
// Assertion macros for the redirect NAT table unit.
// Depends on nothing; included by the top-level unit, which checks its own logic.
`ifndef TCP_REDIRECT_NAT_TABLE_UNIT_ASSERT_SVH
`define TCP_REDIRECT_NAT_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TNT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tcp_redirect_nat_table_unit check failed");
`define TNT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tcp_redirect_nat_table_unit check failed");
`else
`define TNT_ASSERT(label, clk, rst, prop)
`define TNT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### sv/tcpnat_pkg.sv
// Shared types and constants of the redirect NAT table unit.
// Depends on nothing.
package tcpnat_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int SWEEP_W       = 8;
   localparam int CSR_ADDR_W    = 4;

   localparam logic [1:0] REG_PROXY_PORT     = 2'd0;
   localparam logic [1:0] REG_INTERCEPT_PORT = 2'd1;
   localparam logic [1:0] REG_REDIRECT_ADDR  = 2'd2;
   localparam logic [1:0] REG_STALE_TIMEOUT  = 2'd3;

   localparam logic OPC_PACKET = 1'b0;
   localparam logic OPC_LOOKUP = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic        is_tcp_v4;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        flag_syn;
      logic        flag_ack;
      logic        flag_fin;
      logic        flag_rst;
      logic        outbound;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [31:0] new_src_addr;
      logic [31:0] new_dst_addr;
      logic [15:0] new_src_port;
      logic [15:0] new_dst_port;
      logic        modified;
      logic        found;
      logic [31:0] orig_addr;
      logic [15:0] orig_port;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic [31:0] client_addr;
      logic [15:0] client_port;
      logic [31:0] target_addr;
      logic [15:0] target_port;
      logic [31:0] entry_stamp;
   } entry_type;

endpackage

### sv/tcpnat_entry_ram.sv
// Entry store of the redirect NAT table: one write and one registered read port.
// Depends on tcpnat_pkg.
module tcpnat_entry_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tcpnat_pkg::IDX_W-1:0]  wr_idx,
   input  tcpnat_pkg::entry_type         wr_data,
   input  logic [tcpnat_pkg::IDX_W-1:0]  rd_idx,
   output tcpnat_pkg::entry_type         rd_data
);

   tcpnat_pkg::entry_type mem [tcpnat_pkg::TABLE_ENTRIES];
   tcpnat_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/tcp_redirect_nat_table_unit.sv
// Redirect NAT table unit: top level with control sequencer and registers.
// Depends on tcpnat_pkg, tcpnat_entry_ram and the assertion macro header.
// Flow: an item is accepted only in the idle state; the next item is taken once the
// result of the last has been taken. Each item makes one pass over all 64 entries
// through the single RAM read port.
// Reset (synchronous, active high) clears the valid bits and packet count and loads the control registers' defaults.
`include "tcp_redirect_nat_table_unit_assert.svh"
module tcp_redirect_nat_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tcpnat_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tcpnat_pkg::rsp_type               rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tcpnat_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;
   localparam int CNT_W = tcpnat_pkg::IDX_W + 1;
   localparam int N     = tcpnat_pkg::TABLE_ENTRIES;
   localparam logic [tcpnat_pkg::IDX_W-1:0] LAST_IDX = tcpnat_pkg::IDX_W'(N - 1);

   logic [1:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                issue_ff, issue_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [tcpnat_pkg::IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [N-1:0]                    valid_ff, valid_in;
   tcpnat_pkg::req_type             item_ff, item_in;
   logic                            sweep_ff, sweep_in;
   logic [tcpnat_pkg::SWEEP_W-1:0]  pkt_cnt_ff, pkt_cnt_in;
   logic                            hit_s_ff, hit_s_in;
   logic [tcpnat_pkg::IDX_W-1:0]    idx_s_ff, idx_s_in;
   logic [31:0]                     tgt_s_addr_ff, tgt_s_addr_in;
   logic [15:0]                     tgt_s_port_ff, tgt_s_port_in;
   logic                            hit_d_ff, hit_d_in;
   logic [tcpnat_pkg::IDX_W-1:0]    idx_d_ff, idx_d_in;
   logic [31:0]                     tgt_d_addr_ff, tgt_d_addr_in;
   logic [15:0]                     tgt_d_port_ff, tgt_d_port_in;
   logic                            free_ff, free_in;
   logic [tcpnat_pkg::IDX_W-1:0]    free_idx_ff, free_idx_in;
   tcpnat_pkg::rsp_type             rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [15:0]                     proxy_port_ff, proxy_port_in;
   logic [15:0]                     intercept_port_ff, intercept_port_in;
   logic [31:0]                     redirect_addr_ff, redirect_addr_in;
   logic [31:0]                     stale_timeout_ff, stale_timeout_in;

   logic                            req_accept;
   logic                            csr_write;
   logic [1:0]                      csr_reg;
   tcpnat_pkg::entry_type           ent;
   tcpnat_pkg::entry_type           wr_data;
   logic                            wr_en;
   logic [tcpnat_pkg::IDX_W-1:0]    wr_idx;
   logic [31:0]                     age;
   logic                            stale;
   logic                            eff_valid;
   logic                            match_s;
   logic                            match_d;
   logic                            redirect_syn;

   tcpnat_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (issue_ff[tcpnat_pkg::IDX_W-1:0]),
      .rd_data (ent)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_paddr[3:2];

   always_comb begin
      case (csr_reg)
         tcpnat_pkg::REG_PROXY_PORT:     csr_prdata = {16'd0, proxy_port_ff};
         tcpnat_pkg::REG_INTERCEPT_PORT: csr_prdata = {16'd0, intercept_port_ff};
         tcpnat_pkg::REG_REDIRECT_ADDR:  csr_prdata = redirect_addr_ff;
         tcpnat_pkg::REG_STALE_TIMEOUT:  csr_prdata = stale_timeout_ff;
         default:                        csr_prdata = 32'd0;
      endcase
   end

   // shared compare unit: one entry per cycle
   assign age       = item_ff.now_ms - ent.entry_stamp;
   assign stale     = sweep_ff && (age > stale_timeout_ff);
   assign eff_valid = valid_ff[cmp_idx_ff] && !stale;
   assign match_s   = eff_valid && (ent.client_addr == item_ff.src_addr)
                      && (ent.client_port == item_ff.src_port);
   assign match_d   = eff_valid && (ent.client_addr == item_ff.dst_addr)
                      && (ent.client_port == item_ff.dst_port);
   assign redirect_syn = item_ff.flag_syn && !item_ff.flag_ack
                         && (item_ff.dst_port == intercept_port_ff);

   assign wr_data.client_addr = item_ff.src_addr;
   assign wr_data.client_port = item_ff.src_port;
   assign wr_data.target_addr = item_ff.dst_addr;
   assign wr_data.target_port = item_ff.dst_port;
   assign wr_data.entry_stamp = item_ff.now_ms;

   always_comb begin
      state_in          = state_ff;
      issue_in          = issue_ff;
      cmp_vld_in        = 1'b0;
      cmp_idx_in        = cmp_idx_ff;
      valid_in          = valid_ff;
      item_in           = item_ff;
      sweep_in          = sweep_ff;
      pkt_cnt_in        = pkt_cnt_ff;
      hit_s_in          = hit_s_ff;
      idx_s_in          = idx_s_ff;
      tgt_s_addr_in     = tgt_s_addr_ff;
      tgt_s_port_in     = tgt_s_port_ff;
      hit_d_in          = hit_d_ff;
      idx_d_in          = idx_d_ff;
      tgt_d_addr_in     = tgt_d_addr_ff;
      tgt_d_port_in     = tgt_d_port_ff;
      free_in           = free_ff;
      free_idx_in       = free_idx_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff;
      wr_en             = 1'b0;
      wr_idx            = free_idx_ff;
      proxy_port_in     = proxy_port_ff;
      intercept_port_in = intercept_port_ff;
      redirect_addr_in  = redirect_addr_ff;
      stale_timeout_in  = stale_timeout_ff;

      if (csr_write) begin
         case (csr_reg)
            tcpnat_pkg::REG_PROXY_PORT:     proxy_port_in     = csr_pwdata[15:0];
            tcpnat_pkg::REG_INTERCEPT_PORT: intercept_port_in = csr_pwdata[15:0];
            tcpnat_pkg::REG_REDIRECT_ADDR:  redirect_addr_in  = csr_pwdata;
            tcpnat_pkg::REG_STALE_TIMEOUT:  stale_timeout_in  = csr_pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in  = req_data;
               issue_in = '0;
               hit_s_in = 1'b0;
               hit_d_in = 1'b0;
               free_in  = 1'b0;
               sweep_in = 1'b0;
               if (req_data.opcode == tcpnat_pkg::OPC_PACKET) begin
                  pkt_cnt_in = pkt_cnt_ff + 1'b1;
                  sweep_in   = (pkt_cnt_in == '0);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue reads while the compare runs one entry behind
            if (!issue_ff[CNT_W-1]) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[tcpnat_pkg::IDX_W-1:0];
               issue_in   = issue_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               if (stale) begin
                  valid_in[cmp_idx_ff] = 1'b0;
               end
               if (match_s && !hit_s_ff) begin
                  hit_s_in      = 1'b1;
                  idx_s_in      = cmp_idx_ff;
                  tgt_s_addr_in = ent.target_addr;
                  tgt_s_port_in = ent.target_port;
               end
               if (match_d && !hit_d_ff) begin
                  hit_d_in      = 1'b1;
                  idx_d_in      = cmp_idx_ff;
                  tgt_d_addr_in = ent.target_addr;
                  tgt_d_port_in = ent.target_port;
               end
               if (!eff_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            rsp_in = '0;
            if (item_ff.opcode == tcpnat_pkg::OPC_LOOKUP) begin
               if (hit_s_ff) begin
                  rsp_in.found     = 1'b1;
                  rsp_in.orig_addr = tgt_s_addr_ff;
                  rsp_in.orig_port = tgt_s_port_ff;
               end
            end else begin
               rsp_in.new_src_addr = item_ff.src_addr;
               rsp_in.new_dst_addr = item_ff.dst_addr;
               rsp_in.new_src_port = item_ff.src_port;
               rsp_in.new_dst_port = item_ff.dst_port;
               if (item_ff.is_tcp_v4) begin
                  if (redirect_syn) begin
                     if (!item_ff.outbound) begin
                        if (hit_s_ff || free_ff) begin
                           wr_en               = 1'b1;
                           wr_idx              = hit_s_ff ? idx_s_ff : free_idx_ff;
                           valid_in[wr_idx]    = 1'b1;
                           rsp_in.new_dst_addr = redirect_addr_ff;
                           rsp_in.new_dst_port = proxy_port_ff;
                           rsp_in.modified     = 1'b1;
                        end else begin
                           rsp_in.table_full = 1'b1;
                        end
                     end
                  end else begin
                     if (item_ff.outbound && (item_ff.src_port == proxy_port_ff)
                         && hit_d_ff) begin
                        rsp_in.new_src_addr = tgt_d_addr_ff;
                        rsp_in.new_src_port = tgt_d_port_ff;
                        rsp_in.modified     = 1'b1;
                     end
                     if (item_ff.flag_fin || item_ff.flag_rst) begin
                        if (hit_s_ff) begin
                           valid_in[idx_s_ff] = 1'b0;
                        end
                        if (hit_d_ff) begin
                           valid_in[idx_d_ff] = 1'b0;
                        end
                     end
                  end
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         cmp_vld_ff        <= 1'b0;
         valid_ff          <= '0;
         pkt_cnt_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
         proxy_port_ff     <= 16'd8080;
         intercept_port_ff <= 16'd443;
         redirect_addr_ff  <= 32'h7F00_0001;
         stale_timeout_ff  <= 32'd60000;
      end else begin
         state_ff          <= state_in;
         cmp_vld_ff        <= cmp_vld_in;
         valid_ff          <= valid_in;
         pkt_cnt_ff        <= pkt_cnt_in;
         rsp_valid_ff      <= rsp_valid_in;
         proxy_port_ff     <= proxy_port_in;
         intercept_port_ff <= intercept_port_in;
         redirect_addr_ff  <= redirect_addr_in;
         stale_timeout_ff  <= stale_timeout_in;
      end
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      item_ff       <= item_in;
      sweep_ff      <= sweep_in;
      hit_s_ff      <= hit_s_in;
      idx_s_ff      <= idx_s_in;
      tgt_s_addr_ff <= tgt_s_addr_in;
      tgt_s_port_ff <= tgt_s_port_in;
      hit_d_ff      <= hit_d_in;
      idx_d_ff      <= idx_d_in;
      tgt_d_addr_ff <= tgt_d_addr_in;
      tgt_d_port_ff <= tgt_d_port_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

   `TNT_ASSERT(a_accept_starts_scan, clock, reset, req_accept |=> (state_ff == ST_SCAN))
   `TNT_ASSERT(a_rsp_only_in_resp, clock, reset, rsp_valid |-> (state_ff == ST_RESP))
   `TNT_ASSERT(a_full_not_modified, clock, reset, rsp_valid |-> !(rsp_data.table_full && rsp_data.modified))
   `TNT_ASSERT(a_found_is_lookup, clock, reset, rsp_valid && rsp_data.found |-> !rsp_data.modified && !rsp_data.table_full)

endmodule
